### rtl/jcc_pkg.sv
// Shared types and constants for the joystick calibrate-and-classify block.
// Used by the controller, the datapath, the divider and the port checker.
// Has no dependencies of its own.
package jcc_pkg;

	// Input command codes.
	localparam logic [1:0] CMD_RESTART = 2'd0;
	localparam logic [1:0] CMD_CALIB   = 2'd1;
	localparam logic [1:0] CMD_POS     = 2'd2;

	// Direction codes.
	localparam logic [2:0] DIR_NEUTRAL = 3'd0;
	localparam logic [2:0] DIR_RIGHT   = 3'd1;
	localparam logic [2:0] DIR_LEFT    = 3'd2;
	localparam logic [2:0] DIR_UP      = 3'd3;
	localparam logic [2:0] DIR_DOWN    = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] REG_DEF_MAX_X = 2'd0;
	localparam logic [1:0] REG_DEF_MAX_Y = 2'd1;
	localparam logic [1:0] REG_DEF_MIN_X = 2'd2;
	localparam logic [1:0] REG_DEF_MIN_Y = 2'd3;

	localparam logic [7:0] RST_DEF_MAX = 8'd255;
	localparam logic [7:0] RST_DEF_MIN = 8'd0;

	localparam logic signed [15:0] SCALE_FACTOR = 16'sd100;
	localparam logic [15:0]        NEUTRAL_BAND = 16'd5;

	localparam int DIV_NUM_W = 16;
	localparam int DIV_DEN_W = 8;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_XSTART,
		S_XWAIT,
		S_YSTART,
		S_YWAIT,
		S_DONE
	} jcc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic div_start;
		logic div_sel_y;
		logic store_x;
		logic store_y;
		logic load_out;
	} jcc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_pos;
		logic zero_r;
		logic div_done;
		logic out_free;
	} jcc_stat_t;

endpackage

### rtl/jcc_div.sv
// Radix-2 restoring divider for signed operands, quotient truncated toward zero.
// One quotient bit per cycle. Depends on jcc_pkg.
module jcc_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [jcc_pkg::DIV_NUM_W-1:0]  num,
	input  logic signed [jcc_pkg::DIV_DEN_W-1:0]  den,
	output logic                                  done,
	output logic signed [jcc_pkg::DIV_NUM_W-1:0]  quot
);
	import jcc_pkg::*;

	logic                      busy_q;
	logic                      done_q;
	logic [DIV_CNT_W-1:0]      cnt_q;
	logic                      neg_q;
	logic [DIV_DEN_W-1:0]      den_mag_q;
	logic [DIV_DEN_W-1:0]      rem_q;
	logic [DIV_NUM_W-1:0]      quo_q;

	logic [DIV_NUM_W-1:0]      num_mag;
	logic [DIV_DEN_W-1:0]      den_mag;
	logic [DIV_DEN_W:0]        shifted;
	logic [DIV_DEN_W:0]        trial;
	logic                      qbit;

	assign num_mag = num[DIV_NUM_W-1] ? (~num + 1'b1) : num;
	assign den_mag = den[DIV_DEN_W-1] ? (~den + 1'b1) : den;

	// Bring down the next numerator bit and try to subtract the divisor.
	assign shifted = {rem_q, quo_q[DIV_NUM_W-1]};
	assign qbit    = (shifted >= {1'b0, den_mag_q});
	assign trial   = shifted - {1'b0, den_mag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q     <= num[DIV_NUM_W-1] ^ den[DIV_DEN_W-1];
			den_mag_q <= den_mag;
			rem_q     <= '0;
			quo_q     <= num_mag;
		end else if (busy_q) begin
			rem_q <= qbit ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

### rtl/jcc_dp.sv
// Datapath: default and limit registers, centre and radius arithmetic,
// shared divider, direction classifier and output register. Depends on jcc_pkg, jcc_div.
module jcc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [1:0]        cfg_idx,
	input  logic [7:0]        cfg_wdata,
	input  logic [1:0]        command,
	input  logic [7:0]        x_sample,
	input  logic [7:0]        y_sample,
	input  jcc_pkg::jcc_cmd_t ctl,
	output jcc_pkg::jcc_stat_t stat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic [2:0]        direction,
	output logic              zero_radius
);
	import jcc_pkg::*;

	logic [7:0] def_max_x_q, def_max_y_q, def_min_x_q, def_min_y_q;
	logic [7:0] lim_max_x_q, lim_max_y_q, lim_min_x_q, lim_min_y_q;

	logic [1:0] cmd_q;
	logic [7:0] xs_q, ys_q;

	logic signed [15:0] num_x_q, num_y_q;
	logic signed [7:0]  rad_x_q, rad_y_q;
	logic               zero_q;
	logic signed [15:0] px_q, py_q;

	logic               out_valid_q;
	logic signed [15:0] pos_x_q, pos_y_q;
	logic [2:0]         dir_q;
	logic               zr_q;

	logic signed [8:0]  dif_x, dif_y, off_x, off_y;
	logic signed [7:0]  rx, ry;
	logic [8:0]         sum_x, sum_y;
	logic [7:0]         cx, cy;
	logic signed [15:0] nx, ny;

	logic               div_done;
	logic signed [15:0] div_quot;

	logic [15:0]        ax, ay;
	logic [2:0]         dir_new;
	logic               pos_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_max_x_q <= RST_DEF_MAX;
			def_max_y_q <= RST_DEF_MAX;
			def_min_x_q <= RST_DEF_MIN;
			def_min_y_q <= RST_DEF_MIN;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_DEF_MAX_X: def_max_x_q <= cfg_wdata;
				REG_DEF_MAX_Y: def_max_y_q <= cfg_wdata;
				REG_DEF_MIN_X: def_min_x_q <= cfg_wdata;
				REG_DEF_MIN_Y: def_min_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= command;
			xs_q  <= x_sample;
			ys_q  <= y_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_max_x_q <= RST_DEF_MAX;
			lim_max_y_q <= RST_DEF_MAX;
			lim_min_x_q <= RST_DEF_MIN;
			lim_min_y_q <= RST_DEF_MIN;
		end else if (ctl.exec) begin
			case (cmd_q)
				CMD_RESTART: begin
					lim_max_x_q <= def_max_x_q;
					lim_max_y_q <= def_max_y_q;
					lim_min_x_q <= def_min_x_q;
					lim_min_y_q <= def_min_y_q;
				end
				CMD_CALIB: begin
					if (xs_q > lim_max_x_q) lim_max_x_q <= xs_q;
					if (ys_q > lim_max_y_q) lim_max_y_q <= ys_q;
					if (xs_q < lim_min_x_q) lim_min_x_q <= xs_q;
					if (ys_q < lim_min_y_q) lim_min_y_q <= ys_q;
				end
				default: ;
			endcase
		end
	end

	// Radius halves the span toward zero, so a negative odd span rounds up.
	always_comb begin
		dif_x = signed'({1'b0, lim_max_x_q}) - signed'({1'b0, lim_min_x_q});
		dif_y = signed'({1'b0, lim_max_y_q}) - signed'({1'b0, lim_min_y_q});
		rx    = 8'((dif_x + signed'({8'd0, dif_x[8]})) >>> 1);
		ry    = 8'((dif_y + signed'({8'd0, dif_y[8]})) >>> 1);
		sum_x = {1'b0, lim_max_x_q} + {1'b0, lim_min_x_q};
		sum_y = {1'b0, lim_max_y_q} + {1'b0, lim_min_y_q};
		cx    = sum_x[8:1];
		cy    = sum_y[8:1];
		off_x = signed'({1'b0, xs_q}) - signed'({1'b0, cx});
		off_y = signed'({1'b0, ys_q}) - signed'({1'b0, cy});
		nx    = 16'(off_x) * SCALE_FACTOR;
		ny    = 16'(off_y) * SCALE_FACTOR;
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			num_x_q <= nx;
			num_y_q <= ny;
			rad_x_q <= rx;
			rad_y_q <= ry;
			zero_q  <= (rx == 8'sd0) || (ry == 8'sd0);
		end
		if (ctl.store_x) px_q <= div_quot;
		if (ctl.store_y) py_q <= div_quot;
	end

	jcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.num    (ctl.div_sel_y ? num_y_q : num_x_q),
		.den    (ctl.div_sel_y ? rad_y_q : rad_x_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		ax = px_q[15] ? (~px_q + 1'b1) : px_q;
		ay = py_q[15] ? (~py_q + 1'b1) : py_q;
		if ((ax < NEUTRAL_BAND) && (ay < NEUTRAL_BAND)) begin
			dir_new = DIR_NEUTRAL;
		end else if (ax > ay) begin
			dir_new = (px_q > 16'sd0) ? DIR_RIGHT : DIR_LEFT;
		end else begin
			dir_new = (py_q > 16'sd0) ? DIR_UP : DIR_DOWN;
		end
	end

	assign pos_ok = (cmd_q == CMD_POS) && !zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			pos_x_q <= pos_ok ? px_q : 16'sd0;
			pos_y_q <= pos_ok ? py_q : 16'sd0;
			dir_q   <= pos_ok ? dir_new : DIR_NEUTRAL;
			zr_q    <= (cmd_q == CMD_POS) && zero_q;
		end
	end

	assign stat.is_pos   = (cmd_q == CMD_POS);
	assign stat.zero_r   = zero_q;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign direction   = dir_q;
	assign zero_radius = zr_q;

endmodule

### rtl/jcc_ctrl.sv
// Controller state machine: sequences capture, command execution, the two
// divisions and the output load. Depends on jcc_pkg.
module jcc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  jcc_pkg::jcc_stat_t stat,
	output jcc_pkg::jcc_cmd_t  ctl
);
	import jcc_pkg::*;

	jcc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_EXEC;
			S_EXEC: begin
				if (stat.is_pos) begin
					state_d = S_XSTART;
				end else begin
					state_d = S_DONE;
				end
			end
			// A zero radius skips both divisions.
			S_XSTART: state_d = stat.zero_r ? S_DONE : S_XWAIT;
			S_XWAIT:  if (stat.div_done) state_d = S_YSTART;
			S_YSTART: state_d = S_YWAIT;
			S_YWAIT:  if (stat.div_done) state_d = S_DONE;
			S_DONE:   if (stat.out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				ctl.capture = in_valid;
			end
			S_EXEC:   ctl.exec = 1'b1;
			S_XSTART: ctl.div_start = !stat.zero_r;
			S_XWAIT:  ctl.store_x = stat.div_done;
			S_YSTART: begin
				ctl.div_start = 1'b1;
				ctl.div_sel_y = 1'b1;
			end
			S_YWAIT: begin
				ctl.div_sel_y = 1'b1;
				ctl.store_y   = stat.div_done;
			end
			S_DONE:   ctl.load_out = stat.out_free;
			default: ;
		endcase
	end

endmodule

### rtl/joystick_calibrate_and_classify.sv
// Two-axis joystick conditioner. One request is taken at a time. Restart and
// calibration requests pass through the execute and done states until the input is
// ready again, and position requests on a zero radius also pass the x-start state.
// Other position requests use the single radix-2 divider, which produces one quotient
// bit per cycle and serves the x and y axes in turn (16 quotient bits each).
// The last cycle of every request is extended for as long as the previous result is
// still waiting in the output register. A finished result waits in the output register
// while the next request is accepted. Configuration writes take
// effect at the next restart request. Depends on jcc_pkg, jcc_ctrl, jcc_dp.
module joystick_calibrate_and_classify (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [1:0]         cfg_idx,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [7:0]         x_sample,
	input  logic [7:0]         y_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic [2:0]         direction,
	output logic               zero_radius
);
	import jcc_pkg::*;

	jcc_cmd_t  ctl;
	jcc_stat_t stat;

	jcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	jcc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.command     (command),
		.x_sample    (x_sample),
		.y_sample    (y_sample),
		.ctl         (ctl),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.direction   (direction),
		.zero_radius (zero_radius)
	);

endmodule

### rtl/jcc_chk.sv
// Port-level checker for the joystick conditioner, bound to the top level.
// Depends on jcc_pkg.
module jcc_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] pos_x,
	input logic signed [15:0] pos_y,
	input logic [2:0]         direction,
	input logic               zero_radius
);
	import jcc_pkg::*;

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(direction) && $stable(zero_radius))
		else $error("result changed while stalled");

	// Only one request is in flight, so ready drops after each accept.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	a_zero_radius: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_radius |-> pos_x == 16'sd0 && pos_y == 16'sd0
			&& direction == DIR_NEUTRAL)
		else $error("zero radius with nonzero position");

	a_dir_right: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && direction == DIR_RIGHT |-> pos_x > 16'sd0)
		else $error("right direction with non-positive x");

endmodule

bind joystick_calibrate_and_classify jcc_chk u_jcc_chk (.*);
